// ===== rtl/cpp_pkg.sv =====
// ----------------------------------------------------------------------------
// cpp_pkg: shared types and constants of the packed pixel converter
// Holds field widths, configuration register indexes, reset values, the
// configuration and queue entry structs, and the channel clamp function.
// ----------------------------------------------------------------------------
`default_nettype none

package cpp_pkg;

    // Field widths.
    localparam int IN_W      = 18;
    localparam int CH_W      = 16;
    localparam int BYTE_W    = 8;
    localparam int WEIGHT_W  = 9;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GRAY_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_FIRST  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HAS_ALPHA   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_FIRST = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PREMULTIPLY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LUMA_WR     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LUMA_WG     = 3'd6;

    // Reset values of the luma weights.
    localparam logic [WEIGHT_W-1:0] LUMA_WR_RESET = 9'd76;
    localparam logic [WEIGHT_W-1:0] LUMA_WG_RESET = 9'd150;

    // Full weight: the three luma weights should add up to this.
    localparam logic [WEIGHT_W:0] WEIGHT_ONE = 10'd256;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic                gray_mode;
        logic                blue_first;
        logic                has_alpha;
        logic                alpha_first;
        logic                premultiply;
        logic [WEIGHT_W-1:0] luma_wr;
        logic [WEIGHT_W-1:0] luma_wg;
    } t_cfg;

    // One classified pixel waiting for byte emission.
    typedef struct packed {
        logic [BYTE_W-1:0] c0;
        logic [BYTE_W-1:0] c1;
        logic [BYTE_W-1:0] c2;
        logic [BYTE_W-1:0] luma;
        logic [BYTE_W-1:0] alpha;
    } t_entry;

    // Clamp a signed fixed point channel to 0..65535.
    function automatic logic [CH_W-1:0] clamp_channel(input logic [IN_W-1:0] v);
        logic [CH_W-1:0] res;
        if (v[IN_W-1]) begin
            res = '0;
        end else if (v[IN_W-2]) begin
            res = '1;
        end else begin
            res = v[CH_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cpp_ifs.sv =====
// ----------------------------------------------------------------------------
// cpp_ifs: channel interfaces of the packed pixel converter
// Pixel input channel, byte output channel and configuration write channel,
// each with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

// RGBA pixel request channel.
interface cpp_pix_if;
    logic                          valid;
    logic                          ready;
    logic [cpp_pkg::IN_W-1:0]      red;
    logic [cpp_pkg::IN_W-1:0]      green;
    logic [cpp_pkg::IN_W-1:0]      blue;
    logic [cpp_pkg::IN_W-1:0]      alpha;

    modport source (output valid, red, green, blue, alpha, input ready);
    modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

// Packed byte result channel.
interface cpp_byte_if;
    logic                          valid;
    logic                          ready;
    logic [cpp_pkg::BYTE_W-1:0]    out_byte;
    logic                          last_byte;

    modport source (output valid, out_byte, last_byte, input ready);
    modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

// Configuration register write channel.
interface cpp_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [cpp_pkg::CFG_IDX_W-1:0] index;
    logic [cpp_pkg::WEIGHT_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/color_to_packed_pixel.sv =====
// ----------------------------------------------------------------------------
// color_to_packed_pixel: RGBA pixel to packed 8-bit byte stream
// Converts one fixed point RGBA pixel into 1 to 4 bytes: gray or RGB/BGR,
// optional alpha first or last, optional premultiply by alpha.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake     Carries
//  i_pix    in         valid/ready   red, green, blue, alpha (18-bit signed)
//  o_byte   out        valid/ready   out_byte (8 bits), last_byte
//  i_cfg    in         valid/ready   register index (3 bits), data (9 bits)
//
// A pixel yields 1 to 4 bytes at the byte sequencer, which emits one byte each
// cycle while the output is not held; the front accepts one pixel a cycle when not stalled.
// A pixel passes the front stages, the queue and the output register in that order.
// Reset is synchronous and active low; it empties the pipeline and the queue
// and loads the register reset values. The front stalls only when the queue
// is full; the sequencer stalls only when the output register is held.
// ----------------------------------------------------------------------------
`default_nettype none

module color_to_packed_pixel #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cpp_pix_if.sink   i_pix,
    cpp_byte_if.source o_byte,
    cpp_cfg_if.sink   i_cfg
);

    cpp_pkg::t_cfg   r_cfg;
    cpp_pkg::t_entry w_push_entry, w_head_entry;
    logic            w_push, w_pop, w_full, w_head_valid;

    // Configuration registers; writes are always taken.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gray_mode   <= 1'b0;
            r_cfg.blue_first  <= 1'b0;
            r_cfg.has_alpha   <= 1'b1;
            r_cfg.alpha_first <= 1'b0;
            r_cfg.premultiply <= 1'b0;
            r_cfg.luma_wr     <= cpp_pkg::LUMA_WR_RESET;
            r_cfg.luma_wg     <= cpp_pkg::LUMA_WG_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                cpp_pkg::REG_GRAY_MODE:   r_cfg.gray_mode   <= i_cfg.data[0];
                cpp_pkg::REG_BLUE_FIRST:  r_cfg.blue_first  <= i_cfg.data[0];
                cpp_pkg::REG_HAS_ALPHA:   r_cfg.has_alpha   <= i_cfg.data[0];
                cpp_pkg::REG_ALPHA_FIRST: r_cfg.alpha_first <= i_cfg.data[0];
                cpp_pkg::REG_PREMULTIPLY: r_cfg.premultiply <= i_cfg.data[0];
                cpp_pkg::REG_LUMA_WR:     r_cfg.luma_wr     <= i_cfg.data;
                cpp_pkg::REG_LUMA_WG:     r_cfg.luma_wg     <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Front: clamp, premultiply and luma pipeline.
    cpp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .i_cfg   (r_cfg),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_entry (w_push_entry)
    );

    // Queue between the front and the sequencer.
    cpp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_full  (w_full),
        .o_entry (w_head_entry)
    );

    // Back: byte sequencer.
    cpp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_head_valid),
        .i_entry (w_head_entry),
        .o_pop   (w_pop),
        .o_byte  (o_byte)
    );

endmodule

`default_nettype wire

// ===== rtl/cpp_front.sv =====
// ----------------------------------------------------------------------------
// cpp_front: pixel intake and arithmetic pipeline
// Clamps the channels, premultiplies by alpha, weights for luma and hands a
// finished entry with every candidate byte to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cpp_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    cpp_pix_if.sink               i_pix,
    input  wire cpp_pkg::t_cfg    i_cfg,
    input  wire logic             i_full,
    output logic                  o_push,
    output cpp_pkg::t_entry       o_entry
);

    localparam int PROD_W = cpp_pkg::CH_W + cpp_pkg::WEIGHT_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int CH_W   = cpp_pkg::CH_W;
    localparam int BW     = cpp_pkg::BYTE_W;

    logic r_v1, r_v2, r_v3;
    logic w_en;

    // Stage 1 registers: clamped channels.
    logic [CH_W-1:0] r_r1, r_g1, r_b1;
    logic [BW-1:0]   r_a1;
    logic [CH_W-1:0] w_a_clamp;

    // Stage 2 registers: luma inputs and color bytes.
    logic [CH_W-1:0] r_lr2, r_lg2, r_lb2;
    logic [BW-1:0]   r_cr2, r_cg2, r_cb2, r_a2;

    // Stage 3 registers: weighted luma terms and color bytes.
    logic [PROD_W-1:0] r_yr3, r_yg3, r_yb3;
    logic [BW-1:0]     r_cr3, r_cg3, r_cb3, r_a3;

    logic [cpp_pkg::WEIGHT_W-1:0] w_ai;
    logic [PROD_W-1:0]            w_pr, w_pg, w_pb;
    logic                         w_pm;
    logic [cpp_pkg::WEIGHT_W:0]   w_wsum;
    logic [cpp_pkg::WEIGHT_W-1:0] w_wb;
    logic [SUM_W-1:0]             w_ysum;
    logic [BW-1:0]                w_luma;

    // The whole pipeline advances together unless a finished pixel is blocked.
    assign w_en        = !r_v3 || !i_full;
    assign i_pix.ready = w_en;
    assign o_push      = r_v3 && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_pix.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Stage 1: clamp each channel; alpha keeps its top byte.
    assign w_a_clamp = cpp_pkg::clamp_channel(i_pix.alpha);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r1 <= cpp_pkg::clamp_channel(i_pix.red);
            r_g1 <= cpp_pkg::clamp_channel(i_pix.green);
            r_b1 <= cpp_pkg::clamp_channel(i_pix.blue);
            r_a1 <= w_a_clamp[CH_W-1 -: BW];
        end
    end

    // Stage 2: premultiply by alpha plus one when enabled.
    assign w_pm = i_cfg.has_alpha && i_cfg.premultiply;
    assign w_ai = {1'b0, r_a1} + cpp_pkg::WEIGHT_W'(1);
    assign w_pr = PROD_W'(r_r1) * PROD_W'(w_ai);
    assign w_pg = PROD_W'(r_g1) * PROD_W'(w_ai);
    assign w_pb = PROD_W'(r_b1) * PROD_W'(w_ai);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lr2 <= w_pm ? w_pr[BW +: CH_W] : r_r1;
            r_lg2 <= w_pm ? w_pg[BW +: CH_W] : r_g1;
            r_lb2 <= w_pm ? w_pb[BW +: CH_W] : r_b1;
            r_cr2 <= w_pm ? w_pr[CH_W +: BW] : r_r1[CH_W-1 -: BW];
            r_cg2 <= w_pm ? w_pg[CH_W +: BW] : r_g1[CH_W-1 -: BW];
            r_cb2 <= w_pm ? w_pb[CH_W +: BW] : r_b1[CH_W-1 -: BW];
            r_a2  <= r_a1;
        end
    end

    // Stage 3: weight each luma input; blue takes what is left of the full weight.
    assign w_wsum = {1'b0, i_cfg.luma_wr} + {1'b0, i_cfg.luma_wg};
    assign w_wb   = (w_wsum > cpp_pkg::WEIGHT_ONE) ? '0
                  : cpp_pkg::WEIGHT_W'(cpp_pkg::WEIGHT_ONE - w_wsum);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_yr3 <= PROD_W'(r_lr2) * PROD_W'(i_cfg.luma_wr);
            r_yg3 <= PROD_W'(r_lg2) * PROD_W'(i_cfg.luma_wg);
            r_yb3 <= PROD_W'(r_lb2) * PROD_W'(w_wb);
            r_cr3 <= r_cr2;
            r_cg3 <= r_cg2;
            r_cb3 <= r_cb2;
            r_a3  <= r_a2;
        end
    end

    // Sum the luma terms and saturate to one byte.
    assign w_ysum = SUM_W'(r_yr3) + SUM_W'(r_yg3) + SUM_W'(r_yb3);
    assign w_luma = (|w_ysum[SUM_W-1:CH_W+BW]) ? '1 : w_ysum[CH_W +: BW];

    // Color bytes in emit order.
    always_comb begin
        o_entry.c0    = i_cfg.blue_first ? r_cb3 : r_cr3;
        o_entry.c1    = r_cg3;
        o_entry.c2    = i_cfg.blue_first ? r_cr3 : r_cb3;
        o_entry.luma  = w_luma;
        o_entry.alpha = r_a3;
    end

endmodule

`default_nettype wire

// ===== rtl/cpp_queue.sv =====
// ----------------------------------------------------------------------------
// cpp_queue: short queue of classified pixels
// Decouples the arithmetic pipeline from the byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module cpp_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire cpp_pkg::t_entry i_entry,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output logic                 o_full,
    output cpp_pkg::t_entry      o_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cpp_pkg::t_entry  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr, n_wr_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_entry = r_mem[r_rd_ptr];

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cpp_back.sv =====
// ----------------------------------------------------------------------------
// cpp_back: byte sequencer
// Walks through the bytes of the pixel at the head of the queue, one a cycle
// while the output is not held, into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cpp_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire cpp_pkg::t_cfg   i_cfg,
    input  wire logic            i_valid,
    input  wire cpp_pkg::t_entry i_entry,
    output logic                 o_pop,
    cpp_byte_if.source           o_byte
);

    localparam int BW = cpp_pkg::BYTE_W;

    logic [1:0]    r_idx, n_idx;
    logic          r_out_v;
    logic [BW-1:0] r_out_byte;
    logic          r_out_last;

    logic [2:0]    w_count;
    logic          w_lead;
    logic          w_last;
    logic          w_load;
    logic [1:0]    w_cidx;
    logic [BW-1:0] w_color;
    logic [BW-1:0] w_sel;

    // Bytes of this pixel: one luma or three colors, plus alpha if present.
    assign w_count = (i_cfg.gray_mode ? 3'd1 : 3'd3) + {2'b00, i_cfg.has_alpha};
    assign w_lead  = i_cfg.has_alpha && i_cfg.alpha_first;
    assign w_last  = ({1'b0, r_idx} == (w_count - 3'd1));
    assign w_load  = i_valid && (!r_out_v || o_byte.ready);
    assign o_pop   = w_load && w_last;

    // Pick the byte at the current position.
    assign w_cidx = w_lead ? (r_idx - 2'd1) : r_idx;

    always_comb begin
        case (w_cidx)
            2'd0:    w_color = i_entry.c0;
            2'd1:    w_color = i_entry.c1;
            2'd2:    w_color = i_entry.c2;
            default: w_color = i_entry.c2;
        endcase
        if (i_cfg.gray_mode) begin
            w_color = i_entry.luma;
        end
        if (w_lead && r_idx == 2'd0) begin
            w_sel = i_entry.alpha;
        end else if (!w_lead && i_cfg.has_alpha && w_last) begin
            w_sel = i_entry.alpha;
        end else begin
            w_sel = w_color;
        end
    end

    assign n_idx = w_last ? 2'd0 : r_idx + 2'd1;

    // Position counter and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_out_v <= 1'b0;
        end else begin
            if (w_load) begin
                r_idx   <= n_idx;
                r_out_v <= 1'b1;
            end else if (o_byte.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_byte <= w_sel;
            r_out_last <= w_last;
        end
    end

    assign o_byte.valid     = r_out_v;
    assign o_byte.out_byte  = r_out_byte;
    assign o_byte.last_byte = r_out_last;

endmodule

`default_nettype wire

// ===== tb/sv/cpp_checker.sv =====
// ----------------------------------------------------------------------------
// cpp_checker: byte stream predictor and scoreboard for the pixel packer
// Watches the configuration, pixel and byte channels. Keeps its own copy of
// the registers, predicts the packed bytes of every accepted pixel request and
// compares each accepted byte request with the oldest prediction.
// ----------------------------------------------------------------------------
module cpp_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cpp_pix_if        i_pix,
    cpp_byte_if       i_byte,
    cpp_cfg_if        i_cfg,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_bytes_checked
);
    import cpp_pkg::*;

    // Only the first mismatches are printed; all of them are counted.
    localparam int PRINT_CAP = 30;

    typedef struct {
        logic [BYTE_W-1:0] value;
        logic              last;
    } t_packed_byte;

    t_cfg         cfg_shadow;
    t_packed_byte packed_bytes_q[$];
    int           fail_count;
    int           bytes_checked;

    // Saturate a signed fixed point channel to the unsigned 16-bit range.
    function automatic logic [CH_W-1:0] saturate_channel(input logic signed [IN_W-1:0] v);
        if (v < 0) begin
            return '0;
        end
        if (v > 18'sd65535) begin
            return '1;
        end
        return v[CH_W-1:0];
    endfunction

    // Scale a channel by the alpha factor, keeping 16 bits of precision.
    function automatic logic [CH_W-1:0] alpha_scaled(input logic [CH_W-1:0] c,
                                                     input logic [8:0] factor);
        logic [31:0] prod;
        prod = 32'(c) * 32'(factor);
        return prod[23:8];
    endfunction

    // Weighted luma from the register weights; blue takes what is left of 256.
    function automatic logic [BYTE_W-1:0] weighted_luma(input logic [CH_W-1:0] r,
                                                        input logic [CH_W-1:0] g,
                                                        input logic [CH_W-1:0] b);
        longint unsigned wr;
        longint unsigned wg;
        longint unsigned wb;
        longint unsigned y;
        wr = cfg_shadow.luma_wr;
        wg = cfg_shadow.luma_wg;
        wb = (wr + wg > 256) ? 0 : 256 - wr - wg;
        y  = (r * wr + g * wg + b * wb) >> 16;
        // Weights that sum above full scale saturate the luma.
        return (y > 255) ? 8'hFF : y[7:0];
    endfunction

    // Work out the packed bytes of one pixel and queue them in emit order.
    function automatic void predict_pixel(input logic [IN_W-1:0] red,
                                          input logic [IN_W-1:0] green,
                                          input logic [IN_W-1:0] blue,
                                          input logic [IN_W-1:0] alpha);
        logic [CH_W-1:0]   r;
        logic [CH_W-1:0]   g;
        logic [CH_W-1:0]   b;
        logic [CH_W-1:0]   a;
        logic [CH_W-1:0]   first_c;
        logic [CH_W-1:0]   third_c;
        logic [BYTE_W-1:0] a8;
        logic [8:0]        factor;
        logic              pm;
        logic [BYTE_W-1:0] seq[$];
        logic [31:0]       prod;
        t_packed_byte      pb;
        r       = saturate_channel(red);
        g       = saturate_channel(green);
        b       = saturate_channel(blue);
        a       = saturate_channel(alpha);
        a8      = a[15:8];
        factor  = {1'b0, a8} + 9'd1;
        // Premultiply has no effect unless an alpha byte is emitted.
        pm      = cfg_shadow.has_alpha && cfg_shadow.premultiply;
        first_c = cfg_shadow.blue_first ? b : r;
        third_c = cfg_shadow.blue_first ? r : b;

        if (cfg_shadow.has_alpha && cfg_shadow.alpha_first) begin
            seq.push_back(a8);
        end
        if (cfg_shadow.gray_mode) begin
            if (pm) begin
                seq.push_back(weighted_luma(alpha_scaled(r, factor), alpha_scaled(g, factor),
                                            alpha_scaled(b, factor)));
            end else begin
                seq.push_back(weighted_luma(r, g, b));
            end
        end else if (pm) begin
            prod = 32'(first_c) * 32'(factor);
            seq.push_back(prod[23:16]);
            prod = 32'(g) * 32'(factor);
            seq.push_back(prod[23:16]);
            prod = 32'(third_c) * 32'(factor);
            seq.push_back(prod[23:16]);
        end else begin
            seq.push_back(first_c[15:8]);
            seq.push_back(g[15:8]);
            seq.push_back(third_c[15:8]);
        end
        if (cfg_shadow.has_alpha && !cfg_shadow.alpha_first) begin
            seq.push_back(a8);
        end

        foreach (seq[k]) begin
            pb.value = seq[k];
            pb.last  = (k == seq.size() - 1);
            packed_bytes_q.push_back(pb);
        end
    endfunction

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string msg);
        if (fail_count < PRINT_CAP) begin
            $display("mismatch on byte %0d: %s", bytes_checked, msg);
        end
        fail_count++;
    endtask

    // Track register writes, predict accepted pixels and check accepted bytes.
    always @(posedge i_clk) begin
        t_packed_byte exp_b;
        if (!i_rst_n) begin
            cfg_shadow.gray_mode   = 1'b0;
            cfg_shadow.blue_first  = 1'b0;
            cfg_shadow.has_alpha   = 1'b1;
            cfg_shadow.alpha_first = 1'b0;
            cfg_shadow.premultiply = 1'b0;
            cfg_shadow.luma_wr     = LUMA_WR_RESET;
            cfg_shadow.luma_wg     = LUMA_WG_RESET;
            packed_bytes_q.delete();
        end else begin
            // A byte request belongs to a pixel accepted earlier, so check first.
            if (i_byte.valid && i_byte.ready) begin
                if (packed_bytes_q.size() == 0) begin
                    report_mismatch($sformatf("got 0x%02h last %0b with nothing expected",
                                              i_byte.out_byte, i_byte.last_byte));
                end else begin
                    exp_b = packed_bytes_q.pop_front();
                    if (i_byte.out_byte !== exp_b.value) begin
                        report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h",
                                                  i_byte.out_byte, exp_b.value));
                    end
                    if (i_byte.last_byte !== exp_b.last) begin
                        report_mismatch($sformatf("last_byte %0b, expected %0b",
                                                  i_byte.last_byte, exp_b.last));
                    end
                end
                bytes_checked++;
            end

            // Flag writes keep only bit 0; unknown indexes are dropped.
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_GRAY_MODE:   cfg_shadow.gray_mode   = i_cfg.data[0];
                    REG_BLUE_FIRST:  cfg_shadow.blue_first  = i_cfg.data[0];
                    REG_HAS_ALPHA:   cfg_shadow.has_alpha   = i_cfg.data[0];
                    REG_ALPHA_FIRST: cfg_shadow.alpha_first = i_cfg.data[0];
                    REG_PREMULTIPLY: cfg_shadow.premultiply = i_cfg.data[0];
                    REG_LUMA_WR:     cfg_shadow.luma_wr     = i_cfg.data;
                    REG_LUMA_WG:     cfg_shadow.luma_wg     = i_cfg.data;
                    default: begin
                    end
                endcase
            end

            if (i_pix.valid && i_pix.ready) begin
                predict_pixel(i_pix.red, i_pix.green, i_pix.blue, i_pix.alpha);
            end
        end
        o_fail_count    <= fail_count;
        o_pending       <= packed_bytes_q.size();
        o_bytes_checked <= bytes_checked;
    end

    initial begin
        fail_count      = 0;
        bytes_checked   = 0;
        o_fail_count    = 0;
        o_pending       = 0;
        o_bytes_checked = 0;
    end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the RGBA to packed byte converter
// Sends a short set of edge pixels at the reset settings, then random pixels
// under a series of register settings with random gaps on both channels and
// one long output stall. The checker beside the block does all comparison.
// ----------------------------------------------------------------------------
module tb;
    import cpp_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int NUM_PHASES     = 9;
    localparam int PHASE_ITEMS    = 32;
    localparam int NUM_DIRECTED   = 15;
    localparam int LONG_HOLD      = 80;
    localparam int TAIL_CYCLES    = 12;
    // Index past the last register; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending_bytes;
    int   bytes_checked;
    int   pixels_sent;
    int   cycle_count;
    int   hold_request;
    bit   steady_phase;

    cpp_pix_if  pix_ch ();
    cpp_byte_if byte_ch ();
    cpp_cfg_if  cfg_ch ();

    color_to_packed_pixel u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_byte  (byte_ch),
        .i_cfg   (cfg_ch)
    );

    cpp_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_pix           (pix_ch),
        .i_byte          (byte_ch),
        .i_cfg           (cfg_ch),
        .o_fail_count    (fail_count),
        .o_pending       (pending_bytes),
        .o_bytes_checked (bytes_checked)
    );

    // Clock generation.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // Random channel value: anywhere in the field, in range, or on an edge.
    function automatic logic [IN_W-1:0] random_channel();
        logic [IN_W-1:0] edges[8];
        edges = '{18'h00000, 18'h0FFFF, 18'h10000, 18'h1FFFF,
                  18'h20000, 18'h3FFFF, 18'h000FF, 18'h00100};
        case ($urandom_range(0, 3))
            0: return IN_W'($urandom);
            1: return edges[$urandom_range(0, 7)];
            default: return IN_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Offer one pixel request after a random gap and wait until it is taken.
    task automatic send_pixel(input logic [IN_W-1:0] r, input logic [IN_W-1:0] g,
                              input logic [IN_W-1:0] b, input logic [IN_W-1:0] a);
        int gap;
        gap = steady_phase ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.red   <= r;
        pix_ch.green <= g;
        pix_ch.blue  <= b;
        pix_ch.alpha <= a;
        do @(posedge i_clk); while (!pix_ch.ready);
        pixels_sent++;
    endtask

    // Stop offering pixels and wait for every predicted byte to come out.
    task automatic drain_bytes();
        pix_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_bytes != 0) @(posedge i_clk);
    endtask

    // Write every register in a shuffled order, plus the unused index.
    // Single-bit registers get random upper data bits that must be dropped.
    task automatic program_config(input t_cfg c);
        logic [WEIGHT_W-1:0]  wdata[8];
        logic [CFG_IDX_W-1:0] reg_order[$];
        reg_order = '{REG_GRAY_MODE, REG_BLUE_FIRST, REG_HAS_ALPHA, REG_ALPHA_FIRST,
                      REG_PREMULTIPLY, REG_LUMA_WR, REG_LUMA_WG, REG_UNUSED};
        reg_order.shuffle();
        wdata[REG_GRAY_MODE]   = {8'($urandom), c.gray_mode};
        wdata[REG_BLUE_FIRST]  = {8'($urandom), c.blue_first};
        wdata[REG_HAS_ALPHA]   = {8'($urandom), c.has_alpha};
        wdata[REG_ALPHA_FIRST] = {8'($urandom), c.alpha_first};
        wdata[REG_PREMULTIPLY] = {8'($urandom), c.premultiply};
        wdata[REG_LUMA_WR]     = c.luma_wr;
        wdata[REG_LUMA_WG]     = c.luma_wg;
        wdata[REG_UNUSED]      = WEIGHT_W'($urandom);
        foreach (reg_order[k]) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= reg_order[k];
            cfg_ch.data  <= wdata[reg_order[k]];
            do @(posedge i_clk); while (!cfg_ch.ready);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // Byte receiver: random hold-off before each byte, or a long stall on request.
    initial begin : byte_sink
        int gap;
        byte_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request > 0) begin
                gap = hold_request;
                hold_request = 0;
            end else if (steady_phase) begin
                gap = 0;
            end else begin
                gap = $urandom_range(0, 9);
            end
            if (gap > 0) begin
                byte_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            byte_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!byte_ch.valid);
        end
    end

    // Main sequence: reset, edge pixels, then one phase per register setting.
    initial begin : stimulus
        logic [3:0][IN_W-1:0] directed_px[NUM_DIRECTED];
        t_cfg                 setting;
        directed_px = '{
            {18'h00000, 18'h00000, 18'h00000, 18'h00000},
            {18'h0FFFF, 18'h0FFFF, 18'h0FFFF, 18'h0FFFF},
            {18'h20000, 18'h20000, 18'h20000, 18'h20000},
            {18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF},
            {18'h10000, 18'h10000, 18'h10000, 18'h10000},
            {18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF},
            {18'h0FFFF, 18'h00000, 18'h00000, 18'h00000},
            {18'h00000, 18'h0FFFF, 18'h00000, 18'h00000},
            {18'h00000, 18'h00000, 18'h0FFFF, 18'h00000},
            {18'h00000, 18'h00000, 18'h00000, 18'h0FFFF},
            {18'h000FF, 18'h00100, 18'h0FF00, 18'h000FF},
            {18'h00100, 18'h0FEFF, 18'h10001, 18'h00100},
            {18'h20000, 18'h1FFFF, 18'h0FFFF, 18'h10000},
            {18'h12345, 18'h2ABCD, 18'h05555, 18'h0AAAA},
            {18'h0AAAA, 18'h15555, 18'h3AAAA, 18'h05555}
        };
        cycle_count   = 0;
        pixels_sent   = 0;
        hold_request  = 0;
        steady_phase  = 1'b0;
        i_rst_n      <= 1'b0;
        pix_ch.valid <= 1'b0;
        pix_ch.red   <= '0;
        pix_ch.green <= '0;
        pix_ch.blue  <= '0;
        pix_ch.alpha <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_GRAY_MODE;
        cfg_ch.data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Edge pixels at the reset settings.
        foreach (directed_px[k]) begin
            send_pixel(directed_px[k][3], directed_px[k][2], directed_px[k][1],
                       directed_px[k][0]);
        end
        drain_bytes();

        for (int p = 0; p < NUM_PHASES; p++) begin
            // Fields: gray, blue first, has alpha, alpha first, premultiply, wr, wg.
            case (p)
                0: setting = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 9'd256, 9'd256};
                1: setting = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 9'd0,   9'd0};
                2: setting = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 9'd511, 9'd511};
                3: setting = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 9'd0,   9'd0};
                4: setting = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 9'd76,  9'd150};
                5: setting = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 9'd511, 9'd0};
                default: begin
                    setting             = t_cfg'($urandom);
                    setting.gray_mode   = 1'($urandom_range(0, 1));
                    setting.premultiply = 1'($urandom_range(0, 1));
                    setting.luma_wr     = WEIGHT_W'($urandom_range(0, 256));
                    setting.luma_wg     = WEIGHT_W'($urandom_range(0, 256 - setting.luma_wr));
                end
            endcase
            program_config(setting);

            // Two phases run back to back; one of them also holds the output off for a while,
            // so the queue fills and the pixel input has to stall.
            steady_phase = (p == 4) || (p == 7);
            if (p == 4) begin
                hold_request = LONG_HOLD;
            end
            repeat (PHASE_ITEMS) begin
                send_pixel(random_channel(), random_channel(), random_channel(),
                           random_channel());
            end
            drain_bytes();
            steady_phase = 1'b0;
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("run covered %0d pixels and %0d checked bytes over %0d register settings",
                 pixels_sent, bytes_checked, NUM_PHASES + 1);
        $display("gray and color orders, alpha placement, premultiply, luma overflow, stall");
        if (fail_count == 0 && pending_bytes == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
